[rtl/ctr_pkg.sv]
// Shared types and constants for the call trace recorder.
// Used by ctr_ctrl, ctr_datapath and call_trace_recorder_collapse.
`timescale 1ns / 1ps
`default_nettype none
package ctr_pkg;

   localparam int TRACE_DEPTH = 2048;
   localparam int TASK_COUNT  = 256;
   localparam int TRACE_AW    = $clog2(TRACE_DEPTH);
   localparam int POS_W       = $clog2(TRACE_DEPTH + 1);
   localparam int TASK_AW     = $clog2(TASK_COUNT);

   localparam logic [1:0] OP_RECORD  = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [15:0]        COUNT_MAX = 16'hFFFF;
   localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
   localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;

   typedef struct packed {
      logic [10:0]        bp_index;
      logic               is_return;
      logic [15:0]        symbol;
      logic signed [15:0] depth;
      logic [3:0]         cpu;
      logic [7:0]         task_id;
      logic [15:0]        count;
   } trace_rec_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;  // take the input beat, launch memory reads
      logic commit;   // update state, load the result register
      logic drain;    // result beat taken this cycle
   } ctr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;
   } ctr_status_type;

endpackage
`default_nettype wire

[rtl/call_trace_recorder_collapse.sv]
// Top level of the call trace recorder with run collapsing.
// Instantiates ctr_ctrl and ctr_datapath; depends on ctr_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Call/return trace recorder. Each request beat is a record event, a
// trace read or a restart, and gives exactly one response beat. A beat is
// taken only once the last is done: a first step reads the two newest trace
// records and the task's depth from memory (registered reads); a second does
// the collapse compare, writes back at most one record and, on a record event,
// the depth, and loads the response register. A response waiting there does
// not block the next request; only a second finished result waits for it.
// Task depths reset to zero through per-task valid bits, so there is no
// clearing pass after reset. Trace entries beyond the fill level read as 0.
module call_trace_recorder_collapse (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [10:0]        req_bp_index,
   input  wire logic               req_is_return,
   input  wire logic [15:0]        req_symbol,
   input  wire logic [3:0]         req_cpu,
   input  wire logic [7:0]         req_task_id,
   input  wire logic [10:0]        req_read_index,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_recorded,
   output logic [11:0]             rsp_fill_level,
   output logic                    rsp_enabled,
   output logic                    rsp_rd_is_return,
   output logic [10:0]             rsp_rd_bp_index,
   output logic [15:0]             rsp_rd_symbol,
   output logic signed [15:0]      rsp_rd_depth,
   output logic [3:0]              rsp_rd_cpu,
   output logic [7:0]              rsp_rd_task,
   output logic [15:0]             rsp_rd_count
);
   import ctr_pkg::*;

   ctr_cmd_type    cmd;
   ctr_status_type status;

   // sequencer: capture beat, then commit when the response slot frees
   ctr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, pointer, collapse/merge logic, response register
   ctr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_bp_index     (req_bp_index),
      .req_is_return    (req_is_return),
      .req_symbol       (req_symbol),
      .req_cpu          (req_cpu),
      .req_task_id      (req_task_id),
      .req_read_index   (req_read_index),
      .rsp_recorded     (rsp_recorded),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_enabled      (rsp_enabled),
      .rsp_rd_is_return (rsp_rd_is_return),
      .rsp_rd_bp_index  (rsp_rd_bp_index),
      .rsp_rd_symbol    (rsp_rd_symbol),
      .rsp_rd_depth     (rsp_rd_depth),
      .rsp_rd_cpu       (rsp_rd_cpu),
      .rsp_rd_task      (rsp_rd_task),
      .rsp_rd_count     (rsp_rd_count)
   );

   assign rsp_valid = status.out_full;

endmodule
`default_nettype wire

[rtl/ctr_ctrl.sv]
// Controller of the call trace recorder: idle / execute sequencer.
// Depends on ctr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module ctr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    rsp_stall,
   input  wire ctr_pkg::ctr_status_type status,
   output ctr_pkg::ctr_cmd_type         cmd
);
   import ctr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic drain;
   logic out_free;

   assign drain    = status.out_full && !rsp_stall;
   assign out_free = !status.out_full || drain;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      cmd.drain   = drain;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold here until the result register can take the beat
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ctr_datapath.sv]
// Datapath of the call trace recorder: trace memory, depth memory,
// fill pointer, collapse logic and result register. Depends on ctr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctr_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctr_pkg::ctr_cmd_type cmd,
   output ctr_pkg::ctr_status_type   status,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [10:0]          req_bp_index,
   input  wire logic                 req_is_return,
   input  wire logic [15:0]          req_symbol,
   input  wire logic [3:0]           req_cpu,
   input  wire logic [7:0]           req_task_id,
   input  wire logic [10:0]          req_read_index,
   output logic                      rsp_recorded,
   output logic [11:0]               rsp_fill_level,
   output logic                      rsp_enabled,
   output logic                      rsp_rd_is_return,
   output logic [10:0]               rsp_rd_bp_index,
   output logic [15:0]               rsp_rd_symbol,
   output logic signed [15:0]        rsp_rd_depth,
   output logic [3:0]                rsp_rd_cpu,
   output logic [7:0]                rsp_rd_task,
   output logic [15:0]               rsp_rd_count
);
   import ctr_pkg::*;

   // memories
   trace_rec_type      trace_mem [TRACE_DEPTH];
   logic signed [15:0] depth_mem [TASK_COUNT];
   logic [TASK_COUNT-1:0] depth_vld_ff;

   // captured beat
   logic [1:0]  op_ff;
   logic [10:0] bp_ff;
   logic        ret_ff;
   logic [15:0] sym_ff;
   logic [3:0]  cpu_ff;
   logic [7:0]  task_ff;
   logic [10:0] idx_ff;
   logic [TASK_AW-1:0] slot_ff;

   trace_rec_type      rd_a_ff;
   trace_rec_type      rd_b_ff;
   logic signed [15:0] depth_rd_ff;

   logic [POS_W-1:0] wp_ff, wp_in;
   logic             trace_on_ff, trace_on_in;
   logic             out_full_ff;

   trace_rec_type       out_rec_ff;
   logic                out_recorded_ff;
   logic [POS_W-1:0]    out_fill_ff;
   logic                out_enabled_ff;

   // read addresses
   logic [TRACE_AW-1:0] addr_a, addr_b;
   logic [POS_W-1:0]    wp_m1, wp_m2;
   logic [TASK_AW-1:0]  slot;

   assign wp_m1  = wp_ff - POS_W'(1);
   assign wp_m2  = wp_ff - POS_W'(2);
   assign addr_a = (req_opcode == OP_READ) ? TRACE_AW'(req_read_index)
                                           : wp_m1[TRACE_AW-1:0];
   assign addr_b = wp_m2[TRACE_AW-1:0];
   assign slot   = req_task_id[TASK_AW-1:0];

   // commit logic
   logic signed [15:0] old_depth, new_depth;
   logic               rec_ev, hit, merge, append;
   logic [15:0]        p_cnt, q_cnt;
   logic [16:0]        p_sum, q_sum;
   logic               mem_we;
   logic [TRACE_AW-1:0] mem_wa;
   trace_rec_type      mem_wd;
   logic [POS_W-1:0]   wp_p1;
   logic               rd_hit;
   trace_rec_type      rd_out;

   always_comb begin
      old_depth = depth_vld_ff[slot_ff] ? depth_rd_ff : 16'sd0;
      if (ret_ff) begin
         new_depth = (old_depth != DEPTH_MIN) ? old_depth - 16'sd1 : old_depth;
      end else begin
         new_depth = (old_depth != DEPTH_MAX) ? old_depth + 16'sd1 : old_depth;
      end

      rec_ev = (op_ff == OP_RECORD) && trace_on_ff;
      hit    = ret_ff && (wp_ff != '0) && (wp_ff <= POS_W'(TRACE_DEPTH))
               && (rd_a_ff.cpu == cpu_ff) && (rd_a_ff.symbol == sym_ff);
      p_sum  = {1'b0, rd_a_ff.count} + 17'd1;
      p_cnt  = p_sum[16] ? COUNT_MAX : p_sum[15:0];
      q_sum  = {1'b0, rd_b_ff.count} + {1'b0, p_cnt};
      q_cnt  = q_sum[16] ? COUNT_MAX : q_sum[15:0];
      merge  = hit && (wp_ff > POS_W'(1)) && (rd_b_ff.bp_index == rd_a_ff.bp_index)
               && (rd_b_ff.cpu == rd_a_ff.cpu);
      append = rec_ev && !hit && (wp_ff < POS_W'(TRACE_DEPTH));
      wp_p1  = wp_ff + POS_W'(1);

      mem_we = 1'b0;
      mem_wa = wp_m1[TRACE_AW-1:0];
      mem_wd = rd_a_ff;
      wp_in       = wp_ff;
      trace_on_in = trace_on_ff;

      if (op_ff == OP_RESTART) begin
         wp_in       = '0;
         trace_on_in = 1'b1;
      end else if (rec_ev) begin
         if (hit) begin
            mem_we = 1'b1;
            if (merge) begin
               // fold the bumped last record into the one before it
               mem_wa       = wp_m2[TRACE_AW-1:0];
               mem_wd       = rd_b_ff;
               mem_wd.count = q_cnt;
               wp_in        = wp_m1;
            end else begin
               mem_wd.count = p_cnt;
            end
         end else if (append) begin
            mem_we           = 1'b1;
            mem_wa           = wp_ff[TRACE_AW-1:0];
            mem_wd.bp_index  = bp_ff;
            mem_wd.is_return = ret_ff;
            mem_wd.symbol    = sym_ff;
            mem_wd.depth     = new_depth;
            mem_wd.cpu       = cpu_ff;
            mem_wd.task_id   = task_ff;
            mem_wd.count     = 16'd0;
            wp_in            = wp_p1;
            if (wp_p1 >= POS_W'(TRACE_DEPTH)) trace_on_in = 1'b0;
         end else begin
            trace_on_in = 1'b0;  // memory full
         end
      end

      rd_hit = (op_ff == OP_READ) && (POS_W'(idx_ff) < wp_ff);
      rd_out = rd_hit ? rd_a_ff : '0;
   end

   // trace memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         trace_mem[mem_wa] <= mem_wd;
      end
      if (cmd.capture) begin
         rd_a_ff <= trace_mem[addr_a];
         rd_b_ff <= trace_mem[addr_b];
      end
   end

   // depth memory, entries valid once written
   always_ff @(posedge clock) begin
      if (cmd.commit && rec_ev) begin
         depth_mem[slot_ff] <= new_depth;
      end
      if (cmd.capture) begin
         depth_rd_ff <= depth_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         bp_ff   <= req_bp_index;
         ret_ff  <= req_is_return;
         sym_ff  <= req_symbol;
         cpu_ff  <= req_cpu;
         task_ff <= req_task_id;
         idx_ff  <= req_read_index;
         slot_ff <= slot;
      end
      if (cmd.commit) begin
         out_rec_ff      <= rd_out;
         out_recorded_ff <= rec_ev;
         out_fill_ff     <= wp_in;
         out_enabled_ff  <= trace_on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         trace_on_ff  <= 1'b1;
         out_full_ff  <= 1'b0;
         depth_vld_ff <= '0;
      end else begin
         if (cmd.commit) begin
            wp_ff       <= wp_in;
            trace_on_ff <= trace_on_in;
            if (rec_ev) depth_vld_ff[slot_ff] <= 1'b1;
         end
         if (cmd.commit) begin
            out_full_ff <= 1'b1;
         end else if (cmd.drain) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   assign status.out_full = out_full_ff;

   assign rsp_recorded     = out_recorded_ff;
   assign rsp_fill_level   = 12'(out_fill_ff);
   assign rsp_enabled      = out_enabled_ff;
   assign rsp_rd_is_return = out_rec_ff.is_return;
   assign rsp_rd_bp_index  = out_rec_ff.bp_index;
   assign rsp_rd_symbol    = out_rec_ff.symbol;
   assign rsp_rd_depth     = out_rec_ff.depth;
   assign rsp_rd_cpu       = out_rec_ff.cpu;
   assign rsp_rd_task      = out_rec_ff.task_id;
   assign rsp_rd_count     = out_rec_ff.count;

endmodule
`default_nettype wire
